// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the RTL files of the hit detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/mthd_pkg.sv -----
// Types and constants of the median threshold hit detector.
`default_nettype none

package mthd_pkg;

  localparam int unsigned PowerFieldBits = 32;
  localparam int unsigned FactorBits     = 8;
  localparam int unsigned ChanBits       = 4;
  localparam int unsigned CountBits      = 32;
  localparam int unsigned ApbDataBits    = 32;
  localparam int unsigned ApbAddrBits    = 2;

  localparam logic [ApbAddrBits-1:0] RegAddrFactor  = 2'd0;
  localparam logic [FactorBits-1:0]  FactorResetVal = 8'd80;

  typedef struct packed {
    logic [PowerFieldBits-1:0] power_value;
    logic                      locked_out;
  } in_item_t;

  typedef struct packed {
    logic                 hit;
    logic [ChanBits-1:0]  hit_channel;
    logic [CountBits-1:0] channel_hits;
  } out_item_t;

  // Handed from one sort cell to the next.
  typedef struct packed {
    logic gt;   // this cell moves its value one place up
    logic occ;  // this cell holds a value of the current frame
  } chain_link_t;

  // Decision of one frame, handed to the hit counter bank.
  typedef struct packed {
    logic                valid;
    logic                hit;
    logic [ChanBits-1:0] channel;
  } judge_req_t;

endpackage

`default_nettype wire

// ----- rtl/core/mthd_cell.sv -----
// One cell of the insertion sort chain: holds one power value of the frame.
`default_nettype none

module mthd_cell import mthd_pkg::*; #(
  parameter int unsigned POWER_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  shift_en_i,
  input  wire logic                  clear_i,
  input  wire logic [POWER_BITS-1:0] ins_val_i,
  input  wire logic [POWER_BITS-1:0] prev_val_i,
  input  wire chain_link_t           prev_link_i,
  output logic      [POWER_BITS-1:0] val_o,
  output logic      [POWER_BITS-1:0] val_next_o,
  output chain_link_t                link_o
);

  logic [POWER_BITS-1:0] val_q, val_d;
  logic                  occ_q, occ_d;
  logic                  gt;

  // An empty cell always yields, so the new value lands in the first free slot.
  assign gt = !occ_q || (val_q > ins_val_i);

  always_comb begin
    val_d = val_q;
    if (gt) begin
      val_d = prev_link_i.gt ? prev_val_i : ins_val_i;
    end
  end

  assign occ_d = clear_i ? 1'b0 : prev_link_i.occ;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else if (shift_en_i) begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      val_q <= val_d;
    end
  end

  assign val_o      = val_q;
  assign val_next_o = val_d;
  assign link_o     = '{gt: gt, occ: occ_q};

endmodule

`default_nettype wire

// ----- rtl/core/mthd_hit_bank.sv -----
// Per-channel hit counters and the registered result of each frame.
`default_nettype none

module mthd_hit_bank import mthd_pkg::*; #(
  parameter int unsigned CHANNELS = 10
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire judge_req_t req_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output out_item_t       out_data_o
);

  localparam int unsigned IdxBits = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [CountBits-1:0] count_q [CHANNELS];
  logic [IdxBits-1:0]   idx;
  logic [CountBits-1:0] cur_count;
  logic [CountBits-1:0] inc_count;
  logic                 out_valid_q;
  out_item_t            out_q;

  assign idx       = req_i.channel[IdxBits-1:0];
  assign cur_count = count_q[idx];
  assign inc_count = cur_count + CountBits'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        count_q[i] <= '0;
      end
    end else if (req_i.valid && req_i.hit) begin
      count_q[idx] <= inc_count;
    end
  end

  // The top level sends a request only while this register is empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (req_i.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      out_q.hit          <= req_i.hit;
      out_q.hit_channel  <= req_i.channel;
      out_q.channel_hits <= req_i.hit ? inc_count : cur_count;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- rtl/core/median_threshold_hit_detector_unit.sv -----
// Top level of the median threshold hit detector.
//
// Input channel: one transaction per channel power value, channels in order,
// CHANNELS transactions to a frame; locked_out counts on the frame's last one.
// Output channel: one transaction per frame with the hit flag, the strongest
// channel (first one holding the maximum) and that channel's hit count.
// Every value is inserted into a chain of sort cells in the cycle it is taken,
// so the block takes one value per cycle unless in_stall_o holds it off. The
// result of a frame is registered in order: median capture with its last
// value, then multiply, compare, counter update. Only one frame result is
// in flight: the last value of the next frame is held off while the previous
// result is not yet taken, and a stalled result waits in its output register.
// The factor register sits at byte address 0 of the APB port; pready is
// always high. Reset clears the frame position, the hit counters and the
// pipeline, and loads the factor with 80; the block is ready right away.
`default_nettype none

module median_threshold_hit_detector_unit import mthd_pkg::*; #(
  parameter int unsigned CHANNELS   = 10,
  parameter int unsigned MEDIAN_POS = 5,
  parameter int unsigned POWER_BITS = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // item input
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire in_item_t               in_data_i,
  // result output
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output out_item_t                   out_data_o,
  // configuration
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [ApbAddrBits-1:0] paddr,
  input  wire logic [ApbDataBits-1:0] pwdata,
  output logic      [ApbDataBits-1:0] prdata,
  output logic                        pready
);

`include "assert_macros.svh"

  localparam int unsigned PosBits  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned MedPos   = (MEDIAN_POS < CHANNELS) ? MEDIAN_POS : CHANNELS - 1;
  localparam int unsigned InBits   = (POWER_BITS < PowerFieldBits) ? POWER_BITS
                                                                   : PowerFieldBits;
  localparam int unsigned ProdBits = POWER_BITS + FactorBits;
  localparam logic [PosBits-1:0] LastPos = PosBits'(CHANNELS - 1);

  // ---------------- configuration ----------------
  logic [FactorBits-1:0] factor_q;
  logic                  cfg_hit;

  assign cfg_hit = (paddr == RegAddrFactor);
  assign pready  = 1'b1;
  assign prdata  = cfg_hit ? ApbDataBits'(factor_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= FactorResetVal;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      factor_q <= pwdata[FactorBits-1:0];
    end
  end

  // ---------------- frame tracking ----------------
  logic [POWER_BITS-1:0] ins_val;
  logic [PosBits-1:0]    position_q;
  logic [POWER_BITS-1:0] peak_q, peak_d;
  logic [PosBits-1:0]    peak_ch_q, peak_ch_d;
  logic                  last, accept, busy;

  logic                  s1_v_q, s2_v_q, req_v_q;
  logic [POWER_BITS-1:0] s1_med_q, s1_peak_q, s2_peak_q;
  logic [PosBits-1:0]    s1_ch_q, s2_ch_q;
  logic                  s1_lock_q, s2_lock_q;
  logic [ProdBits-1:0]   s2_prod_q;
  logic                  req_hit_q;
  logic [ChanBits-1:0]   req_ch_q;
  judge_req_t            req;

  assign ins_val    = POWER_BITS'(in_data_i.power_value[InBits-1:0]);
  assign last       = (position_q == LastPos);
  assign busy       = s1_v_q || s2_v_q || req_v_q || out_valid_o;
  assign in_stall_o = last && busy;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    peak_d    = peak_q;
    peak_ch_d = peak_ch_q;
    if ((position_q == '0) || (ins_val > peak_q)) begin
      peak_d    = ins_val;
      peak_ch_d = position_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q <= '0;
      peak_q     <= '0;
      peak_ch_q  <= '0;
    end else if (accept) begin
      if (last) begin
        position_q <= '0;
        peak_q     <= '0;
        peak_ch_q  <= '0;
      end else begin
        position_q <= position_q + PosBits'(1);
        peak_q     <= peak_d;
        peak_ch_q  <= peak_ch_d;
      end
    end
  end

  // ---------------- sort chain ----------------
  logic [POWER_BITS-1:0] cell_val  [CHANNELS];
  logic [POWER_BITS-1:0] cell_next [CHANNELS];
  chain_link_t           cell_link [CHANNELS];

  for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
    logic [POWER_BITS-1:0] prev_val;
    chain_link_t           prev_link;

    if (i == 0) begin : g_head
      assign prev_val  = ins_val;
      assign prev_link = '{gt: 1'b0, occ: 1'b1};
    end else begin : g_body
      assign prev_val  = cell_val[i-1];
      assign prev_link = cell_link[i-1];
    end

    mthd_cell #(
      .POWER_BITS(POWER_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_en_i  (accept),
      .clear_i     (last),
      .ins_val_i   (ins_val),
      .prev_val_i  (prev_val),
      .prev_link_i (prev_link),
      .val_o       (cell_val[i]),
      .val_next_o  (cell_next[i]),
      .link_o      (cell_link[i])
    );
  end

  // ---------------- decision pipeline ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      req_v_q <= 1'b0;
    end else begin
      s1_v_q  <= accept && last;
      s2_v_q  <= s1_v_q;
      req_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last) begin
      s1_med_q  <= cell_next[MedPos];
      s1_peak_q <= peak_d;
      s1_ch_q   <= peak_ch_d;
      s1_lock_q <= in_data_i.locked_out;
    end
    s2_prod_q <= ProdBits'(s1_med_q) * ProdBits'(factor_q);
    s2_peak_q <= s1_peak_q;
    s2_ch_q   <= s1_ch_q;
    s2_lock_q <= s1_lock_q;
    req_hit_q <= !s2_lock_q && (ProdBits'(s2_peak_q) > s2_prod_q);
    req_ch_q  <= ChanBits'(s2_ch_q);
  end

  assign req = '{valid: req_v_q, hit: req_hit_q, channel: req_ch_q};

  mthd_hit_bank #(
    .CHANNELS(CHANNELS)
  ) u_hit_bank (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // ---------------- assertions ----------------
  `ASSERT_IMPLY(a_one_in_flight, clk_i, rst_ni, 1'b1,
                $onehot0({s1_v_q, s2_v_q, req_v_q, out_valid_o}))
  `ASSERT_NEXT(a_last_starts_pipe, clk_i, rst_ni, accept && last, s1_v_q)
  `ASSERT_IMPLY(a_pos_in_range, clk_i, rst_ni, 1'b1, position_q <= LastPos)
  `ASSERT_NEXT(a_req_fills_output, clk_i, rst_ni, req_v_q, out_valid_o)

endmodule

`default_nettype wire
